@@ hw/rtl/cctp_pkg.sv @@
// Shared widths, constants and pipeline bundle types for the circumcircle block.
// Depends on nothing; every other file refers to it by scoped names.
package cctp_pkg;

  localparam int COORD_BITS = 12;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQS_W  = 2 * COORD_BITS + 1;
  localparam int BC_W   = 2 * COORD_BITS + 2;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DET_W  = 2 * COORD_BITS + 2;
  localparam int DEN_W  = 2 * COORD_BITS + 2;
  localparam int N_W    = 3 * COORD_BITS + 3;
  localparam int MAG_W  = 3 * COORD_BITS + 2;
  localparam int P_W    = COORD_BITS + DEN_W;
  localparam int UX_W   = 3 * COORD_BITS + 4;
  localparam int U_W    = 3 * COORD_BITS + 3;
  localparam int LO_W   = (U_W + 1) / 2;
  localparam int HI_W   = U_W - LO_W;
  localparam int SQ_W   = 2 * U_W;
  localparam int ROOT_W = (2 * U_W + 10) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int Q_W    = ROOT_W;
  localparam int RES_W  = 32;
  localparam int IN_W   = ((6 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W  = 3 * RES_W;
  localparam int N_LANE = 3;

  localparam logic [RES_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] NEG_MAX = 32'h8000_0000;
  localparam logic [RES_W-1:0] RAD_MAX = 32'hFFFF_FFFF;

  // Lane numbers of the shared divider.
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_R = 2;

  typedef struct packed {
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic             sx;
    logic             sy;
    logic [DEN_W-1:0] d;
    logic             deg;
  } side_t;

  typedef struct packed {
    logic             sx;
    logic             sy;
    logic [DEN_W-1:0] d;
    logic             deg;
  } tag_t;

endpackage

@@ hw/rtl/cctp_geom.sv @@
// Front stages: determinant, center numerators and the radius vector, seven registers deep.
// Depends on cctp_pkg.
module cctp_geom (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ce,
  input  logic                           in_v,
  input  logic [cctp_pkg::COORD_BITS-1:0] x1,
  input  logic [cctp_pkg::COORD_BITS-1:0] y1,
  input  logic [cctp_pkg::COORD_BITS-1:0] x2,
  input  logic [cctp_pkg::COORD_BITS-1:0] y2,
  input  logic [cctp_pkg::COORD_BITS-1:0] x3,
  input  logic [cctp_pkg::COORD_BITS-1:0] y3,
  output logic                           out_v,
  output logic [cctp_pkg::U_W-1:0]       ux_mag,
  output logic [cctp_pkg::U_W-1:0]       uy_mag,
  output cctp_pkg::side_t                side
);

  // stage 1
  logic v1_r;
  logic [cctp_pkg::COORD_BITS-1:0] x2_1_r, y2_1_r;
  logic signed [cctp_pkg::DIFF_W-1:0] a_1_r, b_1_r, c_1_r, e_1_r;
  logic [cctp_pkg::SQS_W-1:0] s1_1_r, s2_1_r, s3_1_r;
  logic signed [cctp_pkg::DIFF_W-1:0] a_nxt, b_nxt, c_nxt, e_nxt;
  logic [2*cctp_pkg::COORD_BITS-1:0] q1x, q1y, q2x, q2y, q3x, q3y;
  // stage 2
  logic v2_r;
  logic [cctp_pkg::COORD_BITS-1:0] x2_2_r, y2_2_r;
  logic signed [cctp_pkg::DIFF_W-1:0] a_2_r, b_2_r, c_2_r, e_2_r;
  logic signed [cctp_pkg::PROD_W-1:0] p1_2_r, p2_2_r;
  logic signed [cctp_pkg::BC_W-1:0] bb_2_r, cc_2_r;
  // stage 3
  logic v3_r;
  logic [cctp_pkg::COORD_BITS-1:0] x2_3_r, y2_3_r;
  logic signed [cctp_pkg::DET_W-1:0] det_3_r;
  logic signed [cctp_pkg::N_W-1:0] t1_3_r, t2_3_r, t3_3_r, t4_3_r;
  // stage 4
  logic v4_r;
  logic [cctp_pkg::COORD_BITS-1:0] x2_4_r, y2_4_r;
  logic signed [cctp_pkg::N_W-1:0] nx_4_r, ny_4_r;
  logic [cctp_pkg::DEN_W-1:0] d_4_r;
  logic neg_4_r, deg_4_r;
  logic signed [cctp_pkg::DET_W-1:0] det_abs;
  // stage 5
  logic v5_r;
  logic signed [cctp_pkg::N_W-1:0] nx_5_r, ny_5_r;
  logic [cctp_pkg::P_W-1:0] px_5_r, py_5_r;
  logic [cctp_pkg::DEN_W-1:0] d_5_r;
  logic deg_5_r;
  // stage 6
  logic v6_r;
  logic signed [cctp_pkg::UX_W-1:0] ux_6_r, uy_6_r;
  logic [cctp_pkg::MAG_W-1:0] mx_6_r, my_6_r;
  logic sx_6_r, sy_6_r;
  logic [cctp_pkg::DEN_W-1:0] d_6_r;
  logic deg_6_r;
  logic signed [cctp_pkg::N_W-1:0] nx_neg, ny_neg;
  // stage 7
  logic v7_r;
  logic [cctp_pkg::U_W-1:0] ux_7_r, uy_7_r;
  cctp_pkg::side_t side_7_r;
  logic signed [cctp_pkg::UX_W-1:0] ux_neg, uy_neg;

  always_comb begin
    a_nxt = $signed({1'b0, x1}) - $signed({1'b0, x2});
    e_nxt = $signed({1'b0, y1}) - $signed({1'b0, y2});
    b_nxt = $signed({1'b0, y2}) - $signed({1'b0, y3});
    c_nxt = $signed({1'b0, x2}) - $signed({1'b0, x3});
    q1x = x1 * x1;
    q1y = y1 * y1;
    q2x = x2 * x2;
    q2y = y2 * y2;
    q3x = x3 * x3;
    q3y = y3 * y3;
    det_abs = det_3_r[cctp_pkg::DET_W-1] ? -det_3_r : det_3_r;
    nx_neg = -nx_5_r;
    ny_neg = -ny_5_r;
    ux_neg = -ux_6_r;
    uy_neg = -uy_6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x2_1_r <= x2;
      y2_1_r <= y2;
      a_1_r  <= a_nxt;
      b_1_r  <= b_nxt;
      c_1_r  <= c_nxt;
      e_1_r  <= e_nxt;
      s1_1_r <= {1'b0, q1x} + {1'b0, q1y};
      s2_1_r <= {1'b0, q2x} + {1'b0, q2y};
      s3_1_r <= {1'b0, q3x} + {1'b0, q3y};

      x2_2_r <= x2_1_r;
      y2_2_r <= y2_1_r;
      a_2_r  <= a_1_r;
      b_2_r  <= b_1_r;
      c_2_r  <= c_1_r;
      e_2_r  <= e_1_r;
      p1_2_r <= a_1_r * b_1_r;
      p2_2_r <= c_1_r * e_1_r;
      bb_2_r <= $signed({1'b0, s1_1_r}) - $signed({1'b0, s2_1_r});
      cc_2_r <= $signed({1'b0, s2_1_r}) - $signed({1'b0, s3_1_r});

      x2_3_r  <= x2_2_r;
      y2_3_r  <= y2_2_r;
      det_3_r <= p1_2_r - p2_2_r;
      t1_3_r  <= bb_2_r * b_2_r;
      t2_3_r  <= cc_2_r * e_2_r;
      t3_3_r  <= cc_2_r * a_2_r;
      t4_3_r  <= bb_2_r * c_2_r;

      x2_4_r  <= x2_3_r;
      y2_4_r  <= y2_3_r;
      nx_4_r  <= t1_3_r - t2_3_r;
      ny_4_r  <= t3_3_r - t4_3_r;
      d_4_r   <= {det_abs[cctp_pkg::DEN_W-2:0], 1'b0};
      neg_4_r <= det_3_r[cctp_pkg::DET_W-1];
      deg_4_r <= (det_3_r == '0);

      // Flip the numerators so that the denominator is positive.
      nx_5_r  <= neg_4_r ? -nx_4_r : nx_4_r;
      ny_5_r  <= neg_4_r ? -ny_4_r : ny_4_r;
      px_5_r  <= x2_4_r * d_4_r;
      py_5_r  <= y2_4_r * d_4_r;
      d_5_r   <= d_4_r;
      deg_5_r <= deg_4_r;

      ux_6_r  <= $signed({2'b00, px_5_r}) - nx_5_r;
      uy_6_r  <= $signed({2'b00, py_5_r}) - ny_5_r;
      mx_6_r  <= nx_5_r[cctp_pkg::N_W-1] ? nx_neg[cctp_pkg::MAG_W-1:0]
                                          : nx_5_r[cctp_pkg::MAG_W-1:0];
      my_6_r  <= ny_5_r[cctp_pkg::N_W-1] ? ny_neg[cctp_pkg::MAG_W-1:0]
                                          : ny_5_r[cctp_pkg::MAG_W-1:0];
      sx_6_r  <= nx_5_r[cctp_pkg::N_W-1];
      sy_6_r  <= ny_5_r[cctp_pkg::N_W-1];
      d_6_r   <= d_5_r;
      deg_6_r <= deg_5_r;

      ux_7_r <= ux_6_r[cctp_pkg::UX_W-1] ? ux_neg[cctp_pkg::U_W-1:0]
                                          : ux_6_r[cctp_pkg::U_W-1:0];
      uy_7_r <= uy_6_r[cctp_pkg::UX_W-1] ? uy_neg[cctp_pkg::U_W-1:0]
                                          : uy_6_r[cctp_pkg::U_W-1:0];
      side_7_r.mx  <= mx_6_r;
      side_7_r.my  <= my_6_r;
      side_7_r.sx  <= sx_6_r;
      side_7_r.sy  <= sy_6_r;
      side_7_r.d   <= d_6_r;
      side_7_r.deg <= deg_6_r;
    end
  end

  assign out_v  = v7_r;
  assign ux_mag = ux_7_r;
  assign uy_mag = uy_7_r;
  assign side   = side_7_r;

endmodule

@@ hw/rtl/cctp_sqsum.sv @@
// Squared length of the radius vector from split partial products, three registers deep.
// Depends on cctp_pkg.
module cctp_sqsum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ce,
  input  logic                       in_v,
  input  logic [cctp_pkg::U_W-1:0]   ux_mag,
  input  logic [cctp_pkg::U_W-1:0]   uy_mag,
  input  cctp_pkg::side_t            side_in,
  output logic                       out_v,
  output logic [cctp_pkg::RAD_W-1:0] rad,
  output cctp_pkg::side_t            side_out
);

  logic v1_r, v2_r, v3_r;
  logic [2*cctp_pkg::LO_W-1:0] xll_r, yll_r;
  logic [cctp_pkg::U_W-1:0] xlh_r, ylh_r;
  logic [2*cctp_pkg::HI_W-1:0] xhh_r, yhh_r;
  logic [cctp_pkg::SQ_W-1:0] sqx_r, sqy_r;
  logic [cctp_pkg::RAD_W-1:0] rad_r;
  cctp_pkg::side_t side1_r, side2_r, side3_r;
  logic [cctp_pkg::SQ_W-1:0] xmid, ymid;
  logic [cctp_pkg::SQ_W:0] sum;

  always_comb begin
    xmid = {{(cctp_pkg::SQ_W-cctp_pkg::U_W-cctp_pkg::LO_W-1){1'b0}},
            xlh_r, {(cctp_pkg::LO_W+1){1'b0}}};
    ymid = {{(cctp_pkg::SQ_W-cctp_pkg::U_W-cctp_pkg::LO_W-1){1'b0}},
            ylh_r, {(cctp_pkg::LO_W+1){1'b0}}};
    sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xll_r <= ux_mag[cctp_pkg::LO_W-1:0] * ux_mag[cctp_pkg::LO_W-1:0];
      xlh_r <= ux_mag[cctp_pkg::LO_W-1:0] * ux_mag[cctp_pkg::U_W-1:cctp_pkg::LO_W];
      xhh_r <= ux_mag[cctp_pkg::U_W-1:cctp_pkg::LO_W] *
               ux_mag[cctp_pkg::U_W-1:cctp_pkg::LO_W];
      yll_r <= uy_mag[cctp_pkg::LO_W-1:0] * uy_mag[cctp_pkg::LO_W-1:0];
      ylh_r <= uy_mag[cctp_pkg::LO_W-1:0] * uy_mag[cctp_pkg::U_W-1:cctp_pkg::LO_W];
      yhh_r <= uy_mag[cctp_pkg::U_W-1:cctp_pkg::LO_W] *
               uy_mag[cctp_pkg::U_W-1:cctp_pkg::LO_W];
      side1_r <= side_in;

      // The high and low squares do not overlap, so they simply concatenate.
      sqx_r   <= {xhh_r, xll_r} + xmid;
      sqy_r   <= {yhh_r, yll_r} + ymid;
      side2_r <= side1_r;

      rad_r   <= {{(cctp_pkg::RAD_W-cctp_pkg::SQ_W-9){1'b0}}, sum, 8'h00};
      side3_r <= side2_r;
    end
  end

  assign out_v    = v3_r;
  assign rad      = rad_r;
  assign side_out = side3_r;

endmodule

@@ hw/rtl/cctp_isqrt.sv @@
// Integer square root, one result bit per register stage.
// Depends on cctp_pkg.
module cctp_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ce,
  input  logic                        in_v,
  input  logic [cctp_pkg::RAD_W-1:0]  rad,
  input  cctp_pkg::side_t             side_in,
  output logic                        out_v,
  output logic [cctp_pkg::ROOT_W-1:0] root,
  output cctp_pkg::side_t             side_out
);

  logic                        v_r    [0:cctp_pkg::ROOT_W-1];
  logic [cctp_pkg::ROOT_W-1:0] root_r [0:cctp_pkg::ROOT_W-1];
  cctp_pkg::side_t             side_r [0:cctp_pkg::ROOT_W-1];
  logic [cctp_pkg::ROOT_W:0]   rem_r  [0:cctp_pkg::ROOT_W-2];
  logic [cctp_pkg::RAD_W-1:0]  rad_r  [0:cctp_pkg::ROOT_W-2];

  for (genvar k = 0; k < cctp_pkg::ROOT_W; k++) begin : g_stage
    logic                        v_p;
    logic [cctp_pkg::ROOT_W-1:0] root_p;
    logic [cctp_pkg::ROOT_W:0]   rem_p;
    logic [cctp_pkg::RAD_W-1:0]  rad_p;
    cctp_pkg::side_t             side_p;
    logic [cctp_pkg::ROOT_W+1:0] sh, trial, diff;
    logic                        ge;
    logic [cctp_pkg::ROOT_W-1:0] root_nxt;
    logic [cctp_pkg::ROOT_W:0]   rem_nxt;

    if (k == 0) begin : g_first
      assign v_p    = in_v;
      assign root_p = '0;
      assign rem_p  = '0;
      assign rad_p  = rad;
      assign side_p = side_in;
    end else begin : g_next
      assign v_p    = v_r[k-1];
      assign root_p = root_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_comb begin
      sh       = {rem_p[cctp_pkg::ROOT_W-1:0], rad_p[cctp_pkg::RAD_W-1 -: 2]};
      trial    = {root_p, 2'b01};
      ge       = (sh >= trial);
      diff     = sh - trial;
      rem_nxt  = ge ? diff[cctp_pkg::ROOT_W:0] : sh[cctp_pkg::ROOT_W:0];
      root_nxt = {root_p[cctp_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        root_r[k] <= root_nxt;
        side_r[k] <= side_p;
      end
    end

    // The last stage needs neither the remainder nor the remaining radicand.
    if (k < cctp_pkg::ROOT_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[k] <= rem_nxt;
          rad_r[k] <= {rad_p[cctp_pkg::RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign out_v    = v_r[cctp_pkg::ROOT_W-1];
  assign root     = root_r[cctp_pkg::ROOT_W-1];
  assign side_out = side_r[cctp_pkg::ROOT_W-1];

endmodule

@@ hw/rtl/cctp_div.sv @@
// Restoring divider with three lanes over one denominator, one quotient bit per stage.
// Depends on cctp_pkg.
module cctp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ce,
  input  logic                       in_v,
  input  logic [cctp_pkg::Q_W-1:0]   num_x,
  input  logic [cctp_pkg::Q_W-1:0]   num_y,
  input  logic [cctp_pkg::Q_W-1:0]   num_r,
  input  cctp_pkg::tag_t             tag_in,
  output logic                       out_v,
  output logic [cctp_pkg::Q_W-1:0]   quo_x,
  output logic [cctp_pkg::Q_W-1:0]   quo_y,
  output logic [cctp_pkg::Q_W-1:0]   quo_r,
  output logic [cctp_pkg::DEN_W-1:0] rem_x,
  output logic [cctp_pkg::DEN_W-1:0] rem_y,
  output cctp_pkg::tag_t             tag_out
);

  logic                       v_r   [0:cctp_pkg::Q_W-1];
  cctp_pkg::tag_t             tag_r [0:cctp_pkg::Q_W-1];
  logic [cctp_pkg::Q_W-1:0]   num_a_r [0:cctp_pkg::Q_W-1][0:cctp_pkg::N_LANE-1];
  logic [cctp_pkg::DEN_W-1:0] rem_a_r [0:cctp_pkg::Q_W-1][0:cctp_pkg::N_LANE-1];
  logic [cctp_pkg::Q_W-1:0]   num_in  [0:cctp_pkg::N_LANE-1];

  always_comb begin
    num_in[cctp_pkg::LANE_X] = num_x;
    num_in[cctp_pkg::LANE_Y] = num_y;
    num_in[cctp_pkg::LANE_R] = num_r;
  end

  for (genvar k = 0; k < cctp_pkg::Q_W; k++) begin : g_stage
    logic           v_p;
    cctp_pkg::tag_t tag_p;

    if (k == 0) begin : g_first
      assign v_p   = in_v;
      assign tag_p = tag_in;
    end else begin : g_next
      assign v_p   = v_r[k-1];
      assign tag_p = tag_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        tag_r[k] <= tag_p;
      end
    end

    for (genvar j = 0; j < cctp_pkg::N_LANE; j++) begin : g_lane
      logic [cctp_pkg::Q_W-1:0]   num_p;
      logic [cctp_pkg::DEN_W-1:0] rem_p;
      logic [cctp_pkg::DEN_W:0]   sh, diff;
      logic                       ge;
      logic [cctp_pkg::Q_W-1:0]   num_nxt;
      logic [cctp_pkg::DEN_W-1:0] rem_nxt;

      if (k == 0) begin : g_first
        assign num_p = num_in[j];
        assign rem_p = '0;
      end else begin : g_next
        assign num_p = num_a_r[k-1][j];
        assign rem_p = rem_a_r[k-1][j];
      end

      always_comb begin
        sh      = {rem_p, num_p[cctp_pkg::Q_W-1]};
        ge      = (sh >= {1'b0, tag_p.d});
        diff    = sh - {1'b0, tag_p.d};
        rem_nxt = ge ? diff[cctp_pkg::DEN_W-1:0] : sh[cctp_pkg::DEN_W-1:0];
        num_nxt = {num_p[cctp_pkg::Q_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (ce) begin
          num_a_r[k][j] <= num_nxt;
          rem_a_r[k][j] <= rem_nxt;
        end
      end
    end
  end

  assign out_v   = v_r[cctp_pkg::Q_W-1];
  assign quo_x   = num_a_r[cctp_pkg::Q_W-1][cctp_pkg::LANE_X];
  assign quo_y   = num_a_r[cctp_pkg::Q_W-1][cctp_pkg::LANE_Y];
  assign quo_r   = num_a_r[cctp_pkg::Q_W-1][cctp_pkg::LANE_R];
  assign rem_x   = rem_a_r[cctp_pkg::Q_W-1][cctp_pkg::LANE_X];
  assign rem_y   = rem_a_r[cctp_pkg::Q_W-1][cctp_pkg::LANE_Y];
  assign tag_out = tag_r[cctp_pkg::Q_W-1];

endmodule

@@ hw/rtl/circumcircle_three_points.sv @@
// Circle through three pixel points, as a stallable pipeline.
// Slave channel in_*: in_tdata carries the three points; a word is taken when
// in_tvalid and in_tready are both high. Master channel out_*: one word per
// input word, in order; out_tdata carries center x, center y (rounded to nearest,
// ties to even, saturated) and the radius in Q28.4, out_tuser flags collinear
// points, in which case out_tdata is all zero.
// From acceptance to out_tvalid a word passes 7 geometry stages, 3 squaring
// stages, 44 square root stages, 44 divider stages, a rounding stage and the
// output register. Throughput is one word per cycle unless out_tready stalls
// the pipeline; the depth is set by the bit-per-stage square root and divider.
// The whole pipeline advances together. While out_tvalid is high and
// out_tready low, every stage holds and in_tready is low, so nothing is lost
// or repeated; bubbles in the pipeline keep their place.
// Synchronous reset clears every valid bit; the first word may be sent in the
// cycle after rst_n rises.
// Depends on cctp_pkg, cctp_geom, cctp_sqsum, cctp_isqrt and cctp_div.
module circumcircle_three_points (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y (12 bits each)
  input  logic [cctp_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // center_x [31:0], center_y [63:32], radius_q4 [95:64]
  output logic [cctp_pkg::OUT_W-1:0]   out_tdata,
  // degenerate
  output logic                         out_tuser
);

  logic ce;

  logic                       geom_v;
  logic [cctp_pkg::U_W-1:0]   ux_mag, uy_mag;
  cctp_pkg::side_t            geom_side;
  logic                       sq_v;
  logic [cctp_pkg::RAD_W-1:0] sq_rad;
  cctp_pkg::side_t            sq_side;
  logic                       rt_v;
  logic [cctp_pkg::ROOT_W-1:0] rt_root;
  cctp_pkg::side_t            rt_side;
  cctp_pkg::tag_t             rt_tag;
  logic                       div_v;
  logic [cctp_pkg::Q_W-1:0]   div_qx, div_qy, div_qr;
  logic [cctp_pkg::DEN_W-1:0] div_rx, div_ry;
  cctp_pkg::tag_t             div_tag;

  logic inc_x, inc_y;
  logic rnd_v_r;
  logic [cctp_pkg::Q_W:0] qx_rnd_r, qy_rnd_r;
  logic [cctp_pkg::Q_W-1:0] qr_rnd_r;
  logic sx_r, sy_r, deg_r;

  logic out_v_r;
  logic [cctp_pkg::OUT_W-1:0] out_data_r;
  logic out_deg_r;
  logic [cctp_pkg::RES_W-1:0] cx_nxt, cy_nxt, rad_nxt;

  assign ce        = !out_v_r || out_tready;
  assign in_tready = ce;

  cctp_geom u_geom (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .in_v   (in_tvalid),
    .x1     (in_tdata[0*cctp_pkg::COORD_BITS +: cctp_pkg::COORD_BITS]),
    .y1     (in_tdata[1*cctp_pkg::COORD_BITS +: cctp_pkg::COORD_BITS]),
    .x2     (in_tdata[2*cctp_pkg::COORD_BITS +: cctp_pkg::COORD_BITS]),
    .y2     (in_tdata[3*cctp_pkg::COORD_BITS +: cctp_pkg::COORD_BITS]),
    .x3     (in_tdata[4*cctp_pkg::COORD_BITS +: cctp_pkg::COORD_BITS]),
    .y3     (in_tdata[5*cctp_pkg::COORD_BITS +: cctp_pkg::COORD_BITS]),
    .out_v  (geom_v),
    .ux_mag (ux_mag),
    .uy_mag (uy_mag),
    .side   (geom_side)
  );

  cctp_sqsum u_sqsum (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_v     (geom_v),
    .ux_mag   (ux_mag),
    .uy_mag   (uy_mag),
    .side_in  (geom_side),
    .out_v    (sq_v),
    .rad      (sq_rad),
    .side_out (sq_side)
  );

  cctp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_v     (sq_v),
    .rad      (sq_rad),
    .side_in  (sq_side),
    .out_v    (rt_v),
    .root     (rt_root),
    .side_out (rt_side)
  );

  always_comb begin
    rt_tag.sx  = rt_side.sx;
    rt_tag.sy  = rt_side.sy;
    rt_tag.d   = rt_side.d;
    rt_tag.deg = rt_side.deg;
  end

  cctp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_v    (rt_v),
    .num_x   ({{(cctp_pkg::Q_W-cctp_pkg::MAG_W){1'b0}}, rt_side.mx}),
    .num_y   ({{(cctp_pkg::Q_W-cctp_pkg::MAG_W){1'b0}}, rt_side.my}),
    .num_r   (rt_root),
    .tag_in  (rt_tag),
    .out_v   (div_v),
    .quo_x   (div_qx),
    .quo_y   (div_qy),
    .quo_r   (div_qr),
    .rem_x   (div_rx),
    .rem_y   (div_ry),
    .tag_out (div_tag)
  );

  // Round half to even on the magnitude; the sign is applied afterwards.
  always_comb begin
    inc_x = ({div_rx, 1'b0} > {1'b0, div_tag.d}) ||
            (({div_rx, 1'b0} == {1'b0, div_tag.d}) && div_qx[0]);
    inc_y = ({div_ry, 1'b0} > {1'b0, div_tag.d}) ||
            (({div_ry, 1'b0} == {1'b0, div_tag.d}) && div_qy[0]);
  end

  always_comb begin
    if (sx_r) begin
      cx_nxt = (qx_rnd_r > {1'b0, cctp_pkg::NEG_MAX}) ? cctp_pkg::NEG_MAX
                                                      : (~qx_rnd_r[cctp_pkg::RES_W-1:0]) + 1'b1;
    end else begin
      cx_nxt = (qx_rnd_r > {1'b0, cctp_pkg::POS_MAX}) ? cctp_pkg::POS_MAX
                                                      : qx_rnd_r[cctp_pkg::RES_W-1:0];
    end
    if (sy_r) begin
      cy_nxt = (qy_rnd_r > {1'b0, cctp_pkg::NEG_MAX}) ? cctp_pkg::NEG_MAX
                                                      : (~qy_rnd_r[cctp_pkg::RES_W-1:0]) + 1'b1;
    end else begin
      cy_nxt = (qy_rnd_r > {1'b0, cctp_pkg::POS_MAX}) ? cctp_pkg::POS_MAX
                                                      : qy_rnd_r[cctp_pkg::RES_W-1:0];
    end
    rad_nxt = (qr_rnd_r > {1'b0, cctp_pkg::RAD_MAX}) ? cctp_pkg::RAD_MAX
                                                     : qr_rnd_r[cctp_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (ce) begin
      rnd_v_r <= div_v;
      out_v_r <= rnd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      qx_rnd_r <= {1'b0, div_qx} + {{cctp_pkg::Q_W{1'b0}}, inc_x};
      qy_rnd_r <= {1'b0, div_qy} + {{cctp_pkg::Q_W{1'b0}}, inc_y};
      qr_rnd_r <= div_qr;
      sx_r     <= div_tag.sx;
      sy_r     <= div_tag.sy;
      deg_r    <= div_tag.deg;

      out_deg_r  <= deg_r;
      out_data_r <= deg_r ? '0 : {rad_nxt, cy_nxt, cx_nxt};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_deg_r;

  // Collinear points give an all-zero word.
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_deg_r |-> out_data_r == '0)
    else $error("degenerate word carries nonzero data");

  // Distinct integer points put the radius at half a pixel or more.
  a_rad_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_deg_r |-> out_data_r[cctp_pkg::OUT_W-1 -: cctp_pkg::RES_W] >= 32'd8)
    else $error("radius below half a pixel for a proper circle");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_v && !div_tag.deg |-> (div_rx < div_tag.d) && (div_ry < div_tag.d))
    else $error("divider remainder not below the denominator");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ce && rnd_v_r |=> out_v_r)
    else $error("rounded word did not reach the output register");

endmodule
